### sv/tssr_pkg.sv
// Shared types, codes and helpers for the tile and sprite scanline renderer.
`default_nettype none

package tssr_pkg;

   localparam int VRAM_BYTES = 8192;
   localparam int VRAM_AW    = 13;
   localparam int CSR_IW     = 4;

   // lcd_control bit positions
   localparam int LCDC_ON      = 7;
   localparam int LCDC_WIN_MAP = 6;
   localparam int LCDC_WIN_ON  = 5;
   localparam int LCDC_BG_MAP  = 3;
   localparam int LCDC_OBJ_ON  = 1;
   localparam int LCDC_BG_ON   = 0;

   localparam logic [1:0] FUNC_VRAM   = 2'd0;
   localparam logic [1:0] FUNC_OAM    = 2'd1;
   localparam logic [1:0] FUNC_RENDER = 2'd2;
   localparam logic [1:0] FUNC_NONE   = 2'd3;

   localparam logic [CSR_IW-1:0] CSR_LCD_CONTROL  = 4'd0;
   localparam logic [CSR_IW-1:0] CSR_SCROLL_Y     = 4'd1;
   localparam logic [CSR_IW-1:0] CSR_SCROLL_X     = 4'd2;
   localparam logic [CSR_IW-1:0] CSR_WINDOW_Y     = 4'd3;
   localparam logic [CSR_IW-1:0] CSR_WINDOW_X     = 4'd4;
   localparam logic [CSR_IW-1:0] CSR_BG_PALETTE   = 4'd5;
   localparam logic [CSR_IW-1:0] CSR_OBJ_PALETTE0 = 4'd6;
   localparam logic [CSR_IW-1:0] CSR_OBJ_PALETTE1 = 4'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [12:0] address;
      logic [7:0]  data;
      logic [7:0]  line;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel_group;
      logic [4:0]  group_index;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [7:0] lcd_control;
      logic [7:0] scroll_y;
      logic [7:0] scroll_x;
      logic [7:0] window_y;
      logic [7:0] window_x;
      logic [7:0] bg_palette;
      logic [7:0] obj_palette0;
      logic [7:0] obj_palette1;
   } cfg_type;

   typedef enum logic [1:0] {
      OP_VRAM,
      OP_OAM,
      OP_RENDER
   } op_type;

   typedef struct packed {
      op_type      op;
      logic [12:0] address;
      logic [7:0]  data;
      logic [7:0]  line;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } cmd_head_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEL_RD,
      ST_SEL_CHK,
      ST_GRP,
      ST_BG_MAP,
      ST_BG_LO,
      ST_BG_HI,
      ST_BG_PIX,
      ST_SP_LO,
      ST_SP_HI,
      ST_SP_MIX,
      ST_OUT
   } state_type;

   function automatic logic [1:0] shade_f(input logic [1:0] colour, input logic [7:0] pal);
      logic [1:0] s;
      s = pal[{colour, 1'b0} +: 2];
      return s;
   endfunction

endpackage

`default_nettype wire

### sv/tssr_front.sv
// Front end: accept commands, classify them and queue them for the renderer.
`default_nettype none

module tssr_front
   import tssr_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output      logic         busy,
   input  wire req_type      req_item,
   input  wire logic         clearing,
   output      cmd_head_type head,
   input  wire logic         pop
);

   cmd_type    q_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept, push;
   cmd_type    cmd_in;

   assign busy   = (count_ff == 2'd2) || clearing;
   assign accept = start && !busy;

   always_comb begin
      cmd_in.address = req_item.address;
      cmd_in.data    = req_item.data;
      cmd_in.line    = req_item.line;
      cmd_in.op      = OP_VRAM;
      push           = accept;
      unique case (req_item.func)
         FUNC_VRAM:   cmd_in.op = OP_VRAM;
         FUNC_OAM:    cmd_in.op = OP_OAM;
         FUNC_RENDER: cmd_in.op = OP_RENDER;
         FUNC_NONE:   push = 1'b0;   // drop unused code
         default:     push = 1'b0;
      endcase
   end

   assign head.valid = (count_ff != 2'd0);
   assign head.cmd   = q_ff[rd_ptr_ff];

   assign wr_ptr_in = wr_ptr_ff ^ push;
   assign rd_ptr_in = rd_ptr_ff ^ pop;
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_in;
      end
   end

endmodule

`default_nettype wire

### sv/tssr_back.sv
// Back end: video memory, sprite table and the line rendering sequencer.
`default_nettype none

module tssr_back
   import tssr_pkg::*;
#(
   parameter int SPRITE_COUNT     = 40,
   parameter int MAX_LINE_SPRITES = 10,
   parameter int SCREEN_WIDTH     = 160
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire cfg_type      cfg,
   input  wire cmd_head_type head,
   output      logic         pop,
   output      logic         clearing,
   output      logic         rsp_valid,
   output      rsp_type      rsp_item
);

   localparam int SIW    = (SPRITE_COUNT > 1) ? $clog2(SPRITE_COUNT) : 1;
   localparam int KW     = $clog2(SPRITE_COUNT + 1);
   localparam int MIW    = (MAX_LINE_SPRITES > 1) ? $clog2(MAX_LINE_SPRITES) : 1;
   localparam int CW     = $clog2(MAX_LINE_SPRITES + 1);
   localparam int GROUPS = SCREEN_WIDTH / 8;
   localparam int OAM_BYTES = 4 * SPRITE_COUNT;

   state_type state_ff, state_in;

   logic [VRAM_AW-1:0] clr_ff;
   logic [7:0]         line_ff;
   logic [KW-1:0]      k_ff;
   logic [CW-1:0]      cnt_ff;
   logic [CW-1:0]      j_ff;
   logic [4:0]         g_ff;
   logic [2:0]         p_ff;
   logic [7:0]         tile_ff;
   logic [7:0]         lo_ff;
   logic [1:0]         grp_ff [8];
   logic [2:0]         sel_row_ff  [MAX_LINE_SPRITES];
   logic [7:0]         sel_x_ff    [MAX_LINE_SPRITES];
   logic [7:0]         sel_tile_ff [MAX_LINE_SPRITES];
   logic               sel_pal_ff  [MAX_LINE_SPRITES];
   logic               rsp_valid_ff;
   rsp_type            rsp_item_ff;

   logic [7:0]         vram_mem [VRAM_BYTES];
   logic [7:0]         vram_rd_ff;
   logic [3:0][7:0]    oam_mem [SPRITE_COUNT];
   logic [3:0][7:0]    oam_rd_ff;

   logic               vram_we;
   logic [VRAM_AW-1:0] vram_waddr, vram_raddr;
   logic [7:0]         vram_wdata;
   logic               oam_we, oam_clr;
   logic [SIW-1:0]     oam_widx, oam_ridx;

   // ---- per-pixel coordinates ----
   logic        bg_on, spr_on, win_hit, msel, sel_hit, sel_last, j_last, g_last;
   logic [7:0]  sx, mx, my;
   logic [9:0]  win_x, sel_d;
   logic [12:0] map_addr;
   logic [2:0]  pix_bit;
   logic [1:0]  bg_colour;
   logic [2:0]  sp_row;
   logic [7:0]  sp_x, sp_tile;
   logic        sp_pal;
   logic [7:0]  sp_palette;
   logic [1:0]  mix_grp [8];
   logic [15:0] packed_grp;

   assign bg_on  = cfg.lcd_control[LCDC_ON] && cfg.lcd_control[LCDC_BG_ON];
   assign spr_on = cfg.lcd_control[LCDC_ON] && cfg.lcd_control[LCDC_OBJ_ON];
   assign sx     = {g_ff, p_ff};

   assign win_x   = {2'b00, sx} + 10'd7 - {2'b00, cfg.window_x};
   assign win_hit = cfg.lcd_control[LCDC_WIN_ON] && (line_ff >= cfg.window_y)
                    && (win_x[9:8] == 2'b00);
   assign mx      = win_hit ? win_x[7:0] : cfg.scroll_x + sx;
   assign my      = win_hit ? line_ff - cfg.window_y : line_ff + cfg.scroll_y;
   assign msel    = win_hit ? cfg.lcd_control[LCDC_WIN_MAP] : cfg.lcd_control[LCDC_BG_MAP];
   // map at 0x9800 or 0x9C00, i.e. offset 0x1800 or 0x1C00
   assign map_addr  = {2'b11, msel, my[7:3], mx[7:3]};
   assign pix_bit   = ~mx[2:0];
   assign bg_colour = {vram_rd_ff[pix_bit], lo_ff[pix_bit]};

   // sprite on this line when line + 16 - y lies in 0..7
   assign sel_d   = {2'b00, line_ff} + 10'd16 - {2'b00, oam_rd_ff[0]};
   assign sel_hit = (sel_d[9:3] == 7'd0) && (oam_rd_ff[1] != 8'd0)
                    && ({2'b00, oam_rd_ff[1]} < 10'(SCREEN_WIDTH + 8));
   assign sel_last = (k_ff == KW'(SPRITE_COUNT - 1))
                     || (sel_hit && (cnt_ff == CW'(MAX_LINE_SPRITES - 1)));

   assign sp_row     = sel_row_ff[j_ff[MIW-1:0]];
   assign sp_x       = sel_x_ff[j_ff[MIW-1:0]];
   assign sp_tile    = sel_tile_ff[j_ff[MIW-1:0]];
   assign sp_pal     = sel_pal_ff[j_ff[MIW-1:0]];
   assign sp_palette = sp_pal ? cfg.obj_palette1 : cfg.obj_palette0;
   assign j_last     = (CW'(j_ff + 1'b1) == cnt_ff);
   assign g_last     = (g_ff == 5'(GROUPS - 1));

   // overlay one sprite row on the eight lanes of the current group
   always_comb begin
      logic [9:0] o;
      logic [2:0] b;
      logic [1:0] c;
      for (int p = 0; p < 8; p++) begin
         o = {2'b00, g_ff, 3'(p)} + 10'd8 - {2'b00, sp_x};
         b = ~o[2:0];
         c = {vram_rd_ff[b], lo_ff[b]};
         mix_grp[p] = grp_ff[p];
         if ((o[9:3] == 7'd0) && (c != 2'd0)) begin
            mix_grp[p] = shade_f(c, sp_palette);
         end
      end
   end

   always_comb begin
      for (int p = 0; p < 8; p++) begin
         packed_grp[15 - 2*p -: 2] = grp_ff[p];
      end
   end

   // ---- next state ----
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == VRAM_AW'(VRAM_BYTES - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (head.valid && head.cmd.op == OP_RENDER) begin
               state_in = spr_on ? ST_SEL_RD : ST_GRP;
            end
         end
         ST_SEL_RD:  state_in = ST_SEL_CHK;
         ST_SEL_CHK: state_in = sel_last ? ST_GRP : ST_SEL_RD;
         ST_GRP: begin
            if (bg_on)                   state_in = ST_BG_MAP;
            else if (cnt_ff != CW'(0))   state_in = ST_SP_LO;
            else                         state_in = ST_OUT;
         end
         ST_BG_MAP: state_in = ST_BG_LO;
         ST_BG_LO:  state_in = ST_BG_HI;
         ST_BG_HI:  state_in = ST_BG_PIX;
         ST_BG_PIX: begin
            if (p_ff != 3'd7)            state_in = ST_BG_MAP;
            else if (cnt_ff != CW'(0))   state_in = ST_SP_LO;
            else                         state_in = ST_OUT;
         end
         ST_SP_LO:  state_in = ST_SP_HI;
         ST_SP_HI:  state_in = ST_SP_MIX;
         ST_SP_MIX: state_in = j_last ? ST_OUT : ST_SP_LO;
         ST_OUT:    state_in = g_last ? ST_IDLE : ST_GRP;
         default:   state_in = ST_IDLE;
      endcase
   end

   // ---- memory control ----
   always_comb begin
      pop        = 1'b0;
      clearing   = 1'b0;
      vram_we    = 1'b0;
      vram_waddr = head.cmd.address;
      vram_wdata = head.cmd.data;
      vram_raddr = '0;
      oam_we     = 1'b0;
      oam_clr    = 1'b0;
      oam_widx   = head.cmd.address[SIW+1:2];
      oam_ridx   = k_ff[SIW-1:0];
      unique case (state_ff)
         ST_CLEAR: begin
            clearing   = 1'b1;
            vram_we    = 1'b1;
            vram_waddr = clr_ff;
            vram_wdata = 8'd0;
            oam_widx   = clr_ff[SIW-1:0];
            oam_clr    = (clr_ff < VRAM_AW'(SPRITE_COUNT));
         end
         ST_IDLE: begin
            pop     = head.valid;
            vram_we = head.valid && (head.cmd.op == OP_VRAM);
            oam_we  = head.valid && (head.cmd.op == OP_OAM)
                      && (head.cmd.address < VRAM_AW'(OAM_BYTES));
         end
         ST_BG_MAP: vram_raddr = map_addr;
         ST_BG_LO:  vram_raddr = {1'b0, vram_rd_ff, my[2:0], 1'b0};
         ST_BG_HI:  vram_raddr = {1'b0, tile_ff, my[2:0], 1'b1};
         ST_SP_LO:  vram_raddr = {1'b0, sp_tile, sp_row, 1'b0};
         ST_SP_HI:  vram_raddr = {1'b0, sp_tile, sp_row, 1'b1};
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (vram_we) begin
         vram_mem[vram_waddr] <= vram_wdata;
      end
      vram_rd_ff <= vram_mem[vram_raddr];
   end

   always_ff @(posedge clock) begin
      if (oam_clr) begin
         oam_mem[oam_widx] <= '0;
      end else if (oam_we) begin
         oam_mem[oam_widx][head.cmd.address[1:0]] <= head.cmd.data;
      end
      oam_rd_ff <= oam_mem[oam_ridx];
   end

   // ---- control registers ----
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         cnt_ff       <= '0;
         j_ff         <= '0;
         g_ff         <= '0;
         p_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_OUT);
         unique case (state_ff)
            ST_CLEAR: clr_ff <= clr_ff + 1'b1;
            ST_IDLE: begin
               k_ff   <= '0;
               cnt_ff <= '0;
               g_ff   <= '0;
            end
            ST_SEL_CHK: begin
               k_ff <= k_ff + 1'b1;
               if (sel_hit) cnt_ff <= cnt_ff + 1'b1;
            end
            ST_GRP: begin
               p_ff <= '0;
               j_ff <= '0;
            end
            ST_BG_PIX: p_ff <= p_ff + 1'b1;
            ST_SP_MIX: j_ff <= j_ff + 1'b1;
            ST_OUT:    g_ff <= g_ff + 1'b1;
            default: begin
            end
         endcase
      end
   end

   // ---- datapath registers ----
   always_ff @(posedge clock) begin
      unique case (state_ff)
         ST_IDLE: line_ff <= head.cmd.line;
         ST_SEL_CHK: begin
            if (sel_hit) begin
               sel_row_ff[cnt_ff[MIW-1:0]]  <= sel_d[2:0];
               sel_x_ff[cnt_ff[MIW-1:0]]    <= oam_rd_ff[1];
               sel_tile_ff[cnt_ff[MIW-1:0]] <= oam_rd_ff[2];
               sel_pal_ff[cnt_ff[MIW-1:0]]  <= oam_rd_ff[3][4];
            end
         end
         ST_GRP: begin
            for (int p = 0; p < 8; p++) grp_ff[p] <= 2'd0;
         end
         ST_BG_LO:  tile_ff <= vram_rd_ff;
         ST_BG_HI:  lo_ff   <= vram_rd_ff;
         ST_BG_PIX: grp_ff[p_ff] <= shade_f(bg_colour, cfg.bg_palette);
         ST_SP_HI:  lo_ff   <= vram_rd_ff;
         ST_SP_MIX: begin
            for (int p = 0; p < 8; p++) grp_ff[p] <= mix_grp[p];
         end
         ST_OUT: begin
            rsp_item_ff.pixel_group <= packed_grp;
            rsp_item_ff.group_index <= g_ff;
            rsp_item_ff.last        <= g_last;
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

### sv/tile_sprite_scanline_renderer.sv
// Top level of the tile and sprite scanline renderer.
//
// After reset the block sweeps its 8 KiB video memory and the sprite table to
// zero, one address a cycle, and busy stays high while it does so. Each command
// is a transfer at a clock edge with start high and busy low. The renderer does
// memory and sprite table writes as it takes them from the queue. A render
// command returns SCREEN_WIDTH/8 pixel groups, each on rsp_item for one cycle
// with rsp_valid; the receiver must take every transfer as it comes. With the
// background on, every pixel costs three reads of the video memory, which has a
// single read port, and every picked sprite costs two reads per group. A
// two-entry command queue sits between the front end and the renderer, so up to
// two commands can be taken while a line is drawn. Configuration registers are
// written through the csr_ port, which is always ready; write them only while
// the block is idle.
`default_nettype none

module tile_sprite_scanline_renderer
   import tssr_pkg::*;
#(
   parameter int SPRITE_COUNT     = 40,
   parameter int MAX_LINE_SPRITES = 10,
   parameter int SCREEN_WIDTH     = 160
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire req_type           req_item,
   output      logic              rsp_valid,
   output      rsp_type           rsp_item,
   input  wire logic              csr_valid,
   output      logic              csr_ready,
   input  wire logic [CSR_IW-1:0] csr_index,
   input  wire logic [7:0]        csr_data
);

   cfg_type      cfg_ff;
   cmd_head_type head;
   logic         pop;
   logic         clearing;

   assign csr_ready = 1'b1;

   // Hold the register file; writes to indexes beyond the list drop.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lcd_control  <= 8'd145;
         cfg_ff.scroll_y     <= 8'd0;
         cfg_ff.scroll_x     <= 8'd0;
         cfg_ff.window_y     <= 8'd0;
         cfg_ff.window_x     <= 8'd0;
         cfg_ff.bg_palette   <= 8'd252;
         cfg_ff.obj_palette0 <= 8'd255;
         cfg_ff.obj_palette1 <= 8'd255;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_LCD_CONTROL:  cfg_ff.lcd_control  <= csr_data;
            CSR_SCROLL_Y:     cfg_ff.scroll_y     <= csr_data;
            CSR_SCROLL_X:     cfg_ff.scroll_x     <= csr_data;
            CSR_WINDOW_Y:     cfg_ff.window_y     <= csr_data;
            CSR_WINDOW_X:     cfg_ff.window_x     <= csr_data;
            CSR_BG_PALETTE:   cfg_ff.bg_palette   <= csr_data;
            CSR_OBJ_PALETTE0: cfg_ff.obj_palette0 <= csr_data;
            CSR_OBJ_PALETTE1: cfg_ff.obj_palette1 <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // Front end: classify commands and queue them.
   tssr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .clearing (clearing),
      .head     (head),
      .pop      (pop)
   );

   // Back end: memories and line sequencer.
   tssr_back #(
      .SPRITE_COUNT     (SPRITE_COUNT),
      .MAX_LINE_SPRITES (MAX_LINE_SPRITES),
      .SCREEN_WIDTH     (SCREEN_WIDTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .head      (head),
      .pop       (pop),
      .clearing  (clearing),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

### sv/tssr_checker.sv
// Port-level checks for the scanline renderer, bound to the top level.
`default_nettype none

module tssr_checker
   import tssr_pkg::*;
#(
   parameter int SCREEN_WIDTH = 160
) (
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    busy,
   input wire logic    rsp_valid,
   input wire rsp_type rsp_item
);

   localparam int GROUPS = SCREEN_WIDTH / 8;

   a_clear_busy: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> busy)
      else $error("busy low right after reset");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.last == (rsp_item.group_index == 5'(GROUPS - 1))))
      else $error("last does not match final group");

   a_index_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ({1'b0, rsp_item.group_index} < 6'(GROUPS)))
      else $error("group index beyond line");

   a_line_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.last |=> !rsp_valid)
      else $error("transfer right after final group");

endmodule

bind tile_sprite_scanline_renderer tssr_checker #(
   .SCREEN_WIDTH (SCREEN_WIDTH)
) u_tssr_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

### verif/tile_sprite_scanline_renderer_test.sv
// Self-checking testbench for the tile and sprite scanline renderer.
`default_nettype none

module tile_sprite_scanline_renderer_test;
   import tssr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_PIXELS  = 160;
   localparam int LINE_GROUPS  = LINE_PIXELS / 8;
   localparam int SPRITES      = 40;
   localparam int LINE_SPR_CAP = 10;
   localparam int TABLE_BYTES  = SPRITES * 4;
   localparam int QUIET_LIMIT  = 30000;   // must outlast the clearing pass after reset
   localparam int DRAIN_CYCLES = 1500;    // settling time after the last group is seen

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   logic [CSR_IW-1:0] csr_index = CSR_LCD_CONTROL;
   logic [7:0] csr_data = '0;

   tile_sprite_scanline_renderer i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shadow copy of the block's stores and registers
   logic [7:0] vram_shadow [VRAM_BYTES];
   logic [7:0] oam_shadow [TABLE_BYTES];
   logic [7:0] reg_shadow [8];

   req_type pending_cmds [$];     // commands not yet offered to the block
   rsp_type pixel_groups_due [$]; // pixel groups predicted, not yet seen

   int  cmds_taken   = 0;
   int  lines_drawn  = 0;
   int  groups_seen  = 0;
   int  csr_taken    = 0;
   int  mismatches   = 0;
   bit  cmd_fired    = 1'b0;
   bit  quiet        = 1'b0;   // no idling on the sending side
   int  gap_left     = 0;

   function automatic logic [1:0] shade_lookup(input logic [1:0] colour, input logic [7:0] pal);
      return 2'((pal >> (2 * colour)) & 8'h3);
   endfunction

   // Colour number of pixel px of tile t, row r; bit 7 is the leftmost pixel.
   function automatic logic [1:0] tile_pixel(input logic [7:0] t, input int r, input int px);
      int base;
      int b;
      base = t * 16 + (r & 7) * 2;
      b = 7 - (px & 7);
      return {vram_shadow[base + 1][b], vram_shadow[base][b]};
   endfunction

   function automatic logic [1:0] map_pixel(input int map_base, input logic [7:0] x,
                                            input logic [7:0] y);
      logic [7:0] t;
      t = vram_shadow[map_base + 32 * (y >> 3) + (x >> 3)];
      return tile_pixel(t, y & 7, x & 7);
   endfunction

   // Work out one screen line and queue its twenty pixel groups.
   function automatic void predict_line(input logic [7:0] line_no);
      logic [1:0] pix [LINE_PIXELS];
      int         picked [$];
      int         ln, k, i, sx, ys, xs, row, map_base;
      logic [7:0] lcdc, by, wy, pal, t;
      logic [1:0] c;
      rsp_type    grp;
      ln = line_no;
      lcdc = reg_shadow[CSR_LCD_CONTROL];
      for (i = 0; i < LINE_PIXELS; i++) pix[i] = 2'd0;
      if (lcdc[LCDC_ON]) begin
         if (lcdc[LCDC_OBJ_ON]) begin
            for (k = 0; k < SPRITES && picked.size() < LINE_SPR_CAP; k++) begin
               ys = int'(oam_shadow[4 * k]) - 16;
               xs = int'(oam_shadow[4 * k + 1]) - 8;
               if (ln >= ys && ln < ys + 8 && xs > -8 && xs < LINE_PIXELS)
                  picked.push_back(k);
            end
         end
         if (lcdc[LCDC_BG_ON]) begin
            by = line_no + reg_shadow[CSR_SCROLL_Y];
            map_base = lcdc[LCDC_BG_MAP] ? 'h1C00 : 'h1800;
            for (i = 0; i < LINE_PIXELS; i++)
               pix[i] = shade_lookup(map_pixel(map_base, 8'(reg_shadow[CSR_SCROLL_X] + i), by),
                                     reg_shadow[CSR_BG_PALETTE]);
            if (lcdc[LCDC_WIN_ON] && line_no >= reg_shadow[CSR_WINDOW_Y]) begin
               wy = line_no - reg_shadow[CSR_WINDOW_Y];
               map_base = lcdc[LCDC_WIN_MAP] ? 'h1C00 : 'h1800;
               sx = int'(reg_shadow[CSR_WINDOW_X]) - 7;
               for (i = 0; i < 256 && sx < LINE_PIXELS; i++, sx++)
                  if (sx >= 0)
                     pix[sx] = shade_lookup(map_pixel(map_base, 8'(i), wy),
                                            reg_shadow[CSR_BG_PALETTE]);
            end
         end
         // Later sprites in the table overwrite earlier ones; colour 0 is clear.
         foreach (picked[n]) begin
            k = picked[n];
            ys = int'(oam_shadow[4 * k]) - 16;
            xs = int'(oam_shadow[4 * k + 1]) - 8;
            t = oam_shadow[4 * k + 2];
            pal = oam_shadow[4 * k + 3][4] ? reg_shadow[CSR_OBJ_PALETTE1]
                                           : reg_shadow[CSR_OBJ_PALETTE0];
            row = ln - ys;
            for (i = 0; i < 8 && xs < LINE_PIXELS; i++, xs++) begin
               c = tile_pixel(t, row, i);
               if (xs >= 0 && c != 2'd0) pix[xs] = shade_lookup(c, pal);
            end
         end
      end
      for (k = 0; k < LINE_GROUPS; k++) begin
         grp.pixel_group = '0;
         for (i = 0; i < 8; i++) grp.pixel_group = {grp.pixel_group[13:0], pix[8 * k + i]};
         grp.group_index = 5'(k);
         grp.last = (k == LINE_GROUPS - 1);
         pixel_groups_due.push_back(grp);
      end
      lines_drawn++;
   endfunction

   // Apply one accepted command to the shadow state.
   function automatic void apply_cmd(input req_type cmd);
      case (cmd.func)
         FUNC_VRAM: vram_shadow[cmd.address] = cmd.data;
         FUNC_OAM: begin
            if (cmd.address < TABLE_BYTES) oam_shadow[cmd.address] = cmd.data;
         end
         FUNC_RENDER: predict_line(cmd.line);
         default: ;   // unused code: drop
      endcase
   endfunction

   // Monitor: sample every transfer at the rising edge.
   int quiet_cycles = 0;
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         quiet_cycles++;
         if (start && !busy) begin
            apply_cmd(req_item);
            cmds_taken++;
            cmd_fired = 1'b1;
            quiet_cycles = 0;
         end
         if (csr_valid && csr_ready) begin
            reg_shadow[csr_index[2:0]] = csr_data;
            csr_taken++;
            quiet_cycles = 0;
         end
         if (rsp_valid) begin
            quiet_cycles = 0;
            groups_seen++;
            if (pixel_groups_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("ERROR: unexpected pixel group %h index %0d last %0b",
                           rsp_item.pixel_group, rsp_item.group_index, rsp_item.last);
            end else begin
               want = pixel_groups_due.pop_front();
               if (rsp_item !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("ERROR: group %0d expected %h/%0d/%0b got %h/%0d/%0b",
                              want.group_index, want.pixel_group, want.group_index, want.last,
                              rsp_item.pixel_group, rsp_item.group_index, rsp_item.last);
               end
            end
         end
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("ERROR: no transfer for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   // Driver: advance to the next command at the falling edge once the current one is taken.
   always @(negedge clock) begin
      if (!reset && (cmd_fired || !start)) begin
         cmd_fired = 1'b0;
         if (gap_left == 0 && !quiet && $urandom_range(0, 5) == 0)
            gap_left = $urandom_range(1, 18);
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_cmds.size() > 0) begin
            start <= 1'b1;
            req_item <= pending_cmds.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   function automatic void queue_cmd(input logic [1:0] func, input int addr, input int data,
                                     input int line_no);
      req_type c;
      c.func = func;
      c.address = 13'(addr);
      c.data = 8'(data);
      c.line = 8'(line_no);
      pending_cmds.push_back(c);
   endfunction

   // Place sprite k so that it covers line_no on row r, at a random column.
   function automatic void queue_sprite(input int k, input int line_no, input int r);
      queue_cmd(FUNC_OAM, 4 * k, line_no + 16 - r, $urandom);
      queue_cmd(FUNC_OAM, 4 * k + 1, $urandom_range(0, 175), $urandom);
      queue_cmd(FUNC_OAM, 4 * k + 2, $urandom_range(0, 15), $urandom);
      queue_cmd(FUNC_OAM, 4 * k + 3, $urandom, $urandom);
   endfunction

   // One random command, biased toward tile data, maps and sprites that show up.
   function automatic void queue_random_cmd();
      int pick, base;
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         base = $urandom_range(0, 3);
         case (base)
            0: queue_cmd(FUNC_VRAM, $urandom_range(0, 255), $urandom, $urandom);
            1: queue_cmd(FUNC_VRAM, 'h1800 + $urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom);
            2: queue_cmd(FUNC_VRAM, 'h1C00 + $urandom_range(0, 1023), $urandom_range(0, 15),
                         $urandom);
            default: queue_cmd(FUNC_VRAM, $urandom, $urandom, $urandom);
         endcase
      end else if (pick < 45) begin
         queue_sprite($urandom_range(0, SPRITES - 1), $urandom_range(0, 143),
                      $urandom_range(0, 7));
      end else if (pick < 52) begin
         queue_cmd(FUNC_OAM, ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 170),
                   $urandom, $urandom);
      end else if (pick < 96) begin
         queue_cmd(FUNC_RENDER, $urandom,  $urandom,
                   ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255)
                                               : $urandom_range(0, 143));
      end else begin
         queue_cmd(FUNC_NONE, $urandom, $urandom, $urandom);
      end
   endfunction

   // Called at a falling edge; returns at the falling edge after the transfer.
   task automatic write_reg(input logic [CSR_IW-1:0] idx, input logic [7:0] value);
      int seen;
      seen = csr_taken;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(negedge clock); while (csr_taken == seen);
   endtask

   // Hold until every command is taken and every group has come, then let the block settle.
   task automatic drain();
      while (pending_cmds.size() > 0 || start || pixel_groups_due.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_all_regs(input logic [7:0] v [8]);
      for (int r = 0; r < 8; r++) write_reg(CSR_IW'(r), v[r]);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      logic [7:0] setting [8];
      int phase, n, k;
      foreach (vram_shadow[a]) vram_shadow[a] = '0;
      foreach (oam_shadow[a]) oam_shadow[a] = '0;
      reg_shadow = '{8'd145, 8'd0, 8'd0, 8'd0, 8'd0, 8'd252, 8'd255, 8'd255};
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: store extremes, ignored writes, unused code, extreme lines.
      queue_cmd(FUNC_RENDER, 0, 0, 0);
      queue_cmd(FUNC_VRAM, 0, 8'hFF, 0);
      queue_cmd(FUNC_VRAM, 1, 8'hAA, 8'hFF);
      queue_cmd(FUNC_VRAM, 8191, 8'hFF, 0);
      queue_cmd(FUNC_VRAM, 'h1800, 8'd0, 0);
      queue_cmd(FUNC_OAM, 0, 16, 0);
      queue_cmd(FUNC_OAM, 1, 8, 0);
      queue_cmd(FUNC_OAM, 2, 0, 0);
      queue_cmd(FUNC_OAM, 3, 8'hFF, 0);
      queue_cmd(FUNC_OAM, 159, 8'hFF, 0);
      queue_cmd(FUNC_OAM, 160, 8'hFF, 0);
      queue_cmd(FUNC_OAM, 8191, 8'hFF, 8'hFF);
      queue_cmd(FUNC_NONE, 8191, 8'hFF, 8'hFF);
      queue_cmd(FUNC_RENDER, 8191, 8'hFF, 0);
      queue_cmd(FUNC_RENDER, 0, 0, 143);
      queue_cmd(FUNC_RENDER, 0, 0, 255);
      // More than ten sprites on one line: selection must stop at ten.
      for (k = 4; k < 16; k++) queue_sprite(k, 40, k & 7);
      queue_cmd(FUNC_RENDER, 0, 0, 40);
      drain();

      // Random phases, each under a different register setting.
      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: setting = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
            1: setting = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
            2: setting = '{8'hA3, 8'h00, 8'h00, 8'h00, 8'h07, 8'hE4, 8'h1B, 8'hD2};
            default: begin
               foreach (setting[r]) setting[r] = 8'($urandom);
               setting[CSR_LCD_CONTROL][LCDC_ON] = ($urandom_range(0, 5) != 0);
               setting[CSR_WINDOW_Y] = 8'($urandom_range(0, 150));
               setting[CSR_WINDOW_X] = 8'($urandom_range(0, 170));
            end
         endcase
         write_all_regs(setting);
         quiet = (phase == 6);
         for (n = 0; n < 15; n++) begin
            // Every so often pile up more than ten sprites on one line, then draw it.
            if ($urandom_range(0, 24) == 0) begin
               k = $urandom_range(0, 143);
               for (int s = 0; s < 12; s++) queue_sprite($urandom_range(0, SPRITES - 1), k,
                                                         $urandom_range(0, 7));
               queue_cmd(FUNC_RENDER, 0, 0, k);
            end else begin
               queue_random_cmd();
            end
         end
         drain();
      end

      $display("Ran %0d commands with %0d register writes; drew %0d lines, checked %0d groups.",
               cmds_taken, csr_taken, lines_drawn, groups_seen);
      $display("Covered register extremes, LCD and background off, window and sprite limit.");
      if (mismatches == 0 && pixel_groups_due.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d groups never arrived", mismatches,
                  pixel_groups_due.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
